/* src/bdpc_pkg.sv */
// Package for the debounced joystick press classifier: phase codes, reset values, flag decode.
package bdpc_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned NumBtn   = 5;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PhaseW   = 3;

  localparam logic [CountW-1:0] DebounceReset  = 16'd50;
  localparam logic [CountW-1:0] LongPressReset = 16'd1000;

  localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd1;

  localparam logic [PhaseW-1:0] PhIdle        = 3'd0;
  localparam logic [PhaseW-1:0] PhSettlePress = 3'd1;
  localparam logic [PhaseW-1:0] PhHold        = 3'd2;
  localparam logic [PhaseW-1:0] PhSettleShort = 3'd3;
  localparam logic [PhaseW-1:0] PhSettleLong  = 3'd4;
  localparam logic [PhaseW-1:0] PhWaitRelease = 3'd5;

  localparam logic [IdxW-1:0]  MaxIdx = 3'd4;

  localparam logic [CodeW-1:0] CodeUp     = 3'd1;
  localparam logic [CodeW-1:0] CodeRight  = 3'd2;
  localparam logic [CodeW-1:0] CodeDown   = 3'd3;
  localparam logic [CodeW-1:0] CodeLeft   = 3'd4;
  localparam logic [CodeW-1:0] CodeCentre = 3'd5;
  localparam logic [CodeW-1:0] CodeNone   = 3'd0;

  // Button code for a single latched flag, CodeNone otherwise.
  function automatic logic [CodeW-1:0] flag_code(input logic [NumBtn-1:0] flags);
    logic [CodeW-1:0] code;
    case (flags)
      5'b00001: code = CodeUp;
      5'b00010: code = CodeRight;
      5'b00100: code = CodeDown;
      5'b01000: code = CodeLeft;
      5'b10000: code = CodeCentre;
      default:  code = CodeNone;
    endcase
    return code;
  endfunction

endpackage

/* src/button_debounce_press_classifier.sv */
// Debounced short/long press classifier for a five-button joystick.
// Each input transaction is a 1 ms tick (cmd 0) or an edge on one button (cmd 1). The block
// takes one transaction per clock; phase, counters and flags update at the accepting edge,
// and a finished press (code 1..5 plus long/short mark) is registered towards the result
// port. Results wait in an output register backed by one skid entry, so input is
// held off only while both are full. Debounce and long-press times are in ticks, set
// through the write port (index 0 debounce, index 1 long press); a value of 0 acts as 1.
module button_debounce_press_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bdpc_pkg::CountW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [bdpc_pkg::IdxW-1:0]       button_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bdpc_pkg::CodeW-1:0]      button_code_o,
  output logic                            long_press_o
);

  logic [bdpc_pkg::CountW-1:0] debounce_ticks_q, long_press_ticks_q;
  logic [bdpc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [bdpc_pkg::CountW-1:0] debounce_count_q, debounce_count_d;
  logic [bdpc_pkg::CountW-1:0] hold_count_q, hold_count_d;
  logic [bdpc_pkg::NumBtn-1:0] edge_flags_q, edge_flags_d;

  logic                        out_valid_q, skid_valid_q;
  logic [bdpc_pkg::CodeW-1:0]  out_code_q, skid_code_q;
  logic                        out_long_q, skid_long_q;

  logic                        in_fire, out_fire, out_free;
  logic                        emit, res_valid, emit_long;
  logic [bdpc_pkg::CodeW-1:0]  emit_code;
  logic [bdpc_pkg::NumBtn-1:0] btn_bit;
  logic                        dbc_expire, hold_expire;

  assign in_ready_o    = !skid_valid_q;
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_fire      = out_valid_q && out_ready_i;
  assign out_free      = out_fire || !out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign button_code_o = out_code_q;
  assign long_press_o  = out_long_q;

  assign btn_bit     = bdpc_pkg::NumBtn'(1) << button_index_i;
  assign dbc_expire  = debounce_count_q <= bdpc_pkg::CountW'(1);
  assign hold_expire = hold_count_q <= bdpc_pkg::CountW'(1);
  assign emit_code   = bdpc_pkg::flag_code(edge_flags_q);
  assign res_valid   = in_fire && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= bdpc_pkg::DebounceReset;
      long_press_ticks_q <= bdpc_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bdpc_pkg::CfgDebounce:  debounce_ticks_q   <= cfg_wdata_i;
        bdpc_pkg::CfgLongPress: long_press_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d          = phase_q;
    debounce_count_d = debounce_count_q;
    hold_count_d     = hold_count_q;
    edge_flags_d     = edge_flags_q;
    emit             = 1'b0;
    emit_long        = 1'b0;
    if (phase_q > bdpc_pkg::PhWaitRelease) begin
      phase_d = bdpc_pkg::PhIdle;
    end
    if (cmd_i) begin
      if (button_index_i <= bdpc_pkg::MaxIdx) begin
        case (phase_q)
          bdpc_pkg::PhSettlePress, bdpc_pkg::PhSettleShort, bdpc_pkg::PhSettleLong: begin
            edge_flags_d     = edge_flags_q | btn_bit;
            debounce_count_d = debounce_ticks_q;
          end
          bdpc_pkg::PhHold: begin
            edge_flags_d     = edge_flags_q | btn_bit;
            debounce_count_d = debounce_ticks_q;
            phase_d          = bdpc_pkg::PhSettleShort;
          end
          bdpc_pkg::PhWaitRelease: begin
            phase_d          = bdpc_pkg::PhIdle;
            edge_flags_d     = '0;
            debounce_count_d = '0;
            hold_count_d     = '0;
          end
          default: begin
            edge_flags_d     = btn_bit;
            debounce_count_d = debounce_ticks_q;
            phase_d          = bdpc_pkg::PhSettlePress;
          end
        endcase
      end else begin
        phase_d = phase_q;
      end
    end else begin
      case (phase_q)
        bdpc_pkg::PhSettlePress: begin
          if (dbc_expire) begin
            debounce_count_d = '0;
            hold_count_d     = long_press_ticks_q;
            phase_d          = bdpc_pkg::PhHold;
          end else begin
            debounce_count_d = debounce_count_q - bdpc_pkg::CountW'(1);
          end
        end
        bdpc_pkg::PhHold: begin
          if (hold_expire) begin
            hold_count_d     = '0;
            debounce_count_d = debounce_ticks_q;
            phase_d          = bdpc_pkg::PhSettleLong;
          end else begin
            hold_count_d = hold_count_q - bdpc_pkg::CountW'(1);
          end
        end
        bdpc_pkg::PhSettleShort, bdpc_pkg::PhSettleLong: begin
          if (dbc_expire) begin
            debounce_count_d = '0;
            emit             = emit_code != bdpc_pkg::CodeNone;
            emit_long        = phase_q == bdpc_pkg::PhSettleLong;
            edge_flags_d     = '0;
            if (phase_q == bdpc_pkg::PhSettleLong) begin
              phase_d = bdpc_pkg::PhWaitRelease;
            end else begin
              phase_d      = bdpc_pkg::PhIdle;
              hold_count_d = '0;
            end
          end else begin
            debounce_count_d = debounce_count_q - bdpc_pkg::CountW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= bdpc_pkg::PhIdle;
      debounce_count_q <= '0;
      hold_count_q     <= '0;
      edge_flags_q     <= '0;
    end else if (in_fire) begin
      phase_q          <= phase_d;
      debounce_count_q <= debounce_count_d;
      hold_count_q     <= hold_count_d;
      edge_flags_q     <= edge_flags_d;
    end
  end

  // output register plus one skid entry; skid always holds the newer result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_valid;
      end else begin
        out_valid_q  <= res_valid;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_code_q <= skid_code_q;
        out_long_q <= skid_long_q;
        if (res_valid) begin
          skid_code_q <= emit_code;
          skid_long_q <= emit_long;
        end
      end else if (res_valid) begin
        out_code_q <= emit_code;
        out_long_q <= emit_long;
      end
    end else if (res_valid) begin
      skid_code_q <= emit_code;
      skid_long_q <= emit_long;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_code_q != bdpc_pkg::CodeNone) && (out_code_q <= bdpc_pkg::CodeCentre))
    else $error("result carries an invalid button code");

  a_idle_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bdpc_pkg::PhIdle || phase_q == bdpc_pkg::PhWaitRelease)
      |-> edge_flags_q == '0)
    else $error("button flags latched while idle or waiting for release");

  a_result_from_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(phase_q) == bdpc_pkg::PhSettleShort ||
                            $past(phase_q) == bdpc_pkg::PhSettleLong))
    else $error("result produced outside a release/long settle phase");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("skid entry lost while output stalled");

endmodule
